[sv/dect_pkg.sv]
// Package for the dual edge contour tracer: constants, direction tables,
// controller state type and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package dect_pkg;

    localparam int IMAGE_WIDTH  = 188;
    localparam int IMAGE_HEIGHT = 120;
    localparam int POINT_LIMIT  = 240;
    localparam int MEET_DIST    = 5;
    localparam int FRAME_SIZE   = IMAGE_WIDTH * IMAGE_HEIGHT;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_STEPS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic write_pix;
        logic start;
        logic begin_step;
        logic rd0;
        logic rd1;
        logic take_hit;
        logic next_pair;
        logic stop;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic live;
        logic at_limit;
        logic hit;
        logic last_pair;
        logic out_free;
    } t_sts;

    // x step of direction d; the right tracker mirrors the left one
    function automatic logic signed [1:0] dx_of(input logic side, input logic [2:0] d);
        logic signed [1:0] v;
        unique case (d)
            3'd1, 3'd2, 3'd3: v = 2'sb01;
            3'd5, 3'd6, 3'd7: v = 2'sb11;
            default:          v = 2'sb00;
        endcase
        return side ? -v : v;
    endfunction

    function automatic logic signed [1:0] dy_of(input logic [2:0] d);
        logic signed [1:0] v;
        unique case (d)
            3'd0, 3'd1, 3'd7: v = 2'sb11;
            3'd3, 3'd4, 3'd5: v = 2'sb01;
            default:          v = 2'sb00;
        endcase
        return v;
    endfunction

endpackage

[sv/dect_req_if.sv]
// Request channel of the contour tracer: valid/ready plus item fields.
// Depends on nothing.
`timescale 1ns / 1ps
interface dect_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [14:0] pixel_index;
    logic [7:0] pixel_value;
    logic [7:0] left_start_x;
    logic [6:0] left_start_y;
    logic [7:0] right_start_x;
    logic [6:0] right_start_y;

    modport source (output valid, mode, pixel_index, pixel_value, left_start_x,
                    left_start_y, right_start_x, right_start_y, input ready);
    modport sink (input valid, mode, pixel_index, pixel_value, left_start_x,
                  left_start_y, right_start_x, right_start_y, output ready);
endinterface

[sv/dect_rsp_if.sv]
// Result channel of the contour tracer: valid/ready plus result fields.
// Depends on nothing.
`timescale 1ns / 1ps
interface dect_rsp_if;
    logic       valid;
    logic       ready;
    logic       side;
    logic       found;
    logic [7:0] point_x;
    logic [6:0] point_y;
    logic [2:0] heading;
    logic [7:0] point_number;
    logic       left_running;
    logic       right_running;
    logic       finished;

    modport source (output valid, side, found, point_x, point_y, heading, point_number,
                    left_running, right_running, finished, input ready);
    modport sink (input valid, side, found, point_x, point_y, heading, point_number,
                  left_running, right_running, finished, output ready);
endinterface

[sv/dect_datapath.sv]
// Datapath of the contour tracer: frame memory, tracker registers, probe
// addressing and result register. Depends on dect_pkg and dect_rsp_if.
`timescale 1ns / 1ps
module dect_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic [14:0]          i_pixel_index,
    input  logic [7:0]           i_pixel_value,
    input  logic [7:0]           i_left_start_x,
    input  logic [6:0]           i_left_start_y,
    input  logic [7:0]           i_right_start_x,
    input  logic [6:0]           i_right_start_y,
    input  dect_pkg::t_cmd       i_cmd,
    output dect_pkg::t_sts       o_sts,
    dect_rsp_if.source           o_rsp
);

    logic [7:0]  mem [dect_pkg::FRAME_SIZE];
    logic [7:0]  r_rdata, r_v0, r_thr;
    logic [15:0] r_max, r_steps;
    logic        r_in0, r_in1;
    logic [7:0]  r_lx, r_rx, r_lcnt, r_rcnt;
    logic [6:0]  r_ly, r_ry;
    logic [2:0]  r_ldir, r_rdir, r_k;
    logic        r_la, r_ra, r_done, r_side, r_found, r_out_valid;

    logic        side_new, done_new, meet, in_frame;
    logic [7:0]  cur_x, sel_cnt;
    logic [6:0]  cur_y;
    logic [2:0]  cur_dir, d0, d1, pd;
    logic signed [1:0] dxv, dyv;
    logic [9:0]  px;
    logic [8:0]  py, adx, ady;
    logic [14:0] addr;

    assign side_new = (r_la && r_ra) ? (r_ly < r_ry) : r_ra;
    assign sel_cnt  = side_new ? r_rcnt : r_lcnt;
    assign cur_x    = r_side ? r_rx : r_lx;
    assign cur_y    = r_side ? r_ry : r_ly;
    assign cur_dir  = r_side ? r_rdir : r_ldir;
    assign d1       = cur_dir + r_k;
    assign d0       = d1 - 3'd1;
    assign pd       = i_cmd.rd0 ? d0 : d1;
    assign dxv      = dect_pkg::dx_of(r_side, pd);
    assign dyv      = dect_pkg::dy_of(pd);
    assign px       = {2'b00, cur_x} + {{8{dxv[1]}}, dxv};
    assign py       = {2'b00, cur_y} + {{7{dyv[1]}}, dyv};
    assign in_frame = !px[9] && (px < 10'(dect_pkg::IMAGE_WIDTH))
                   && !py[8] && (py < 9'(dect_pkg::IMAGE_HEIGHT));
    assign addr     = in_frame ? 15'({7'b0, py[7:0]} * 15'(dect_pkg::IMAGE_WIDTH)
                                     + {6'b0, px[8:0]}) : '0;

    assign adx  = (r_lx >= r_rx) ? {1'b0, r_lx - r_rx} : {1'b0, r_rx - r_lx};
    assign ady  = (r_ly >= r_ry) ? {2'b0, r_ly - r_ry} : {2'b0, r_ry - r_ly};
    assign meet = r_la && r_ra && (adx < 9'(dect_pkg::MEET_DIST))
               && (ady < 9'(dect_pkg::MEET_DIST));
    assign done_new = (r_steps == '0) || (!r_la && !r_ra) || meet;

    assign o_sts.live      = !r_done && (r_la || r_ra);
    assign o_sts.at_limit  = sel_cnt >= 8'(dect_pkg::POINT_LIMIT - 1);
    assign o_sts.hit       = r_in0 && r_in1 && (r_v0 < r_thr) && (r_rdata > r_thr);
    assign o_sts.last_pair = (r_k == 3'd7);
    assign o_sts.out_free  = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_pix && (i_pixel_index < 15'(dect_pkg::FRAME_SIZE))) begin
            mem[i_pixel_index] <= i_pixel_value;
        end
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd0) begin
            r_in0 <= in_frame;
        end
        if (i_cmd.rd1) begin
            r_in1 <= in_frame;
            r_v0  <= r_rdata;
        end
        if (i_cmd.emit) begin
            o_rsp.side          <= r_side;
            o_rsp.found         <= r_found;
            o_rsp.point_x       <= cur_x;
            o_rsp.point_y       <= cur_y;
            o_rsp.heading       <= cur_dir;
            o_rsp.point_number  <= r_side ? r_rcnt : r_lcnt;
            o_rsp.left_running  <= r_la;
            o_rsp.right_running <= r_ra;
            o_rsp.finished      <= done_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 8'd128;
            r_max <= 16'd480;
            r_lx <= '0; r_ly <= '0; r_ldir <= '0; r_lcnt <= '0; r_la <= 1'b0;
            r_rx <= '0; r_ry <= '0; r_rdir <= '0; r_rcnt <= '0; r_ra <= 1'b0;
            r_steps <= '0;
            r_done <= 1'b1;
            r_side <= 1'b0;
            r_found <= 1'b0;
            r_k <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dect_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[7:0];
                    dect_pkg::CFG_MAX_STEPS: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_lx <= i_left_start_x;  r_ly <= i_left_start_y;
                r_rx <= i_right_start_x; r_ry <= i_right_start_y;
                r_ldir <= '0; r_rdir <= '0; r_lcnt <= '0; r_rcnt <= '0;
                r_la <= 1'b1; r_ra <= 1'b1;
                r_steps <= r_max;
                r_done <= (r_max == '0);
            end
            if (i_cmd.begin_step) begin
                r_steps <= r_steps - 16'd1;
                r_side  <= side_new;
                r_k     <= '0;
                r_found <= 1'b0;
                if (o_sts.at_limit) begin
                    if (side_new) r_ra <= 1'b0;
                    else          r_la <= 1'b0;
                end
            end
            if (i_cmd.next_pair) begin
                r_k <= r_k + 3'd1;
            end
            if (i_cmd.stop) begin
                if (r_side) r_ra <= 1'b0;
                else        r_la <= 1'b0;
            end
            if (i_cmd.take_hit) begin
                r_found <= 1'b1;
                if (r_side) begin
                    r_rx <= px[7:0]; r_ry <= py[6:0]; r_rdir <= d1; r_rcnt <= r_rcnt + 8'd1;
                end else begin
                    r_lx <= px[7:0]; r_ly <= py[6:0]; r_ldir <= d1; r_lcnt <= r_lcnt + 8'd1;
                end
            end
            if (i_cmd.emit) begin
                r_done <= done_new;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[sv/dect_ctrl.sv]
// Controller of the contour tracer: sequences request intake, probe pair
// reads and result emission. Depends on dect_pkg.
`timescale 1ns / 1ps
module dect_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_mode,
    output logic           o_ready,
    output dect_pkg::t_cmd o_cmd,
    input  dect_pkg::t_sts i_sts
);

    dect_pkg::t_state r_state, n_state;
    logic acc;

    assign acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dect_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dect_pkg::S_IDLE: begin
                if (acc && i_mode == dect_pkg::MODE_STEP && i_sts.live) begin
                    n_state = i_sts.at_limit ? dect_pkg::S_EMIT : dect_pkg::S_RD0;
                end
            end
            dect_pkg::S_RD0: n_state = dect_pkg::S_RD1;
            dect_pkg::S_RD1: n_state = dect_pkg::S_CMP;
            dect_pkg::S_CMP: begin
                if (i_sts.hit || i_sts.last_pair) n_state = dect_pkg::S_EMIT;
                else                              n_state = dect_pkg::S_RD0;
            end
            dect_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = dect_pkg::S_IDLE;
            end
            default: n_state = dect_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            dect_pkg::S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.write_pix  = acc && i_mode == dect_pkg::MODE_LOAD;
                o_cmd.start      = acc && i_mode == dect_pkg::MODE_START;
                o_cmd.begin_step = acc && i_mode == dect_pkg::MODE_STEP && i_sts.live;
            end
            dect_pkg::S_RD0: o_cmd.rd0 = 1'b1;
            dect_pkg::S_RD1: o_cmd.rd1 = 1'b1;
            dect_pkg::S_CMP: begin
                o_cmd.take_hit  = i_sts.hit;
                o_cmd.stop      = !i_sts.hit && i_sts.last_pair;
                o_cmd.next_pair = !i_sts.hit && !i_sts.last_pair;
            end
            dect_pkg::S_EMIT: o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

    a_hit_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dect_pkg::S_CMP && i_sts.hit) |=> r_state == dect_pkg::S_EMIT)
        else $error("hit did not lead to emit");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.rd0, o_cmd.rd1, o_cmd.take_hit, o_cmd.next_pair,
                  o_cmd.stop, o_cmd.emit, o_cmd.begin_step}))
        else $error("conflicting datapath commands");

    a_read_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dect_pkg::S_RD0) |=> r_state == dect_pkg::S_RD1)
        else $error("probe pair read broken");

endmodule

[sv/dual_edge_contour_tracer_unit.sv]
// Top level of the dual edge contour tracer: controller plus datapath.
// Depends on dect_pkg, dect_req_if, dect_rsp_if, dect_ctrl, dect_datapath.
//
// Usage: requests arrive on i_req (valid/ready). Mode load writes one pixel
// of the 188x120 frame memory, mode start seeds both trackers and loads the
// step budget, mode step advances one tracker and yields one result on
// o_rsp. Load, start and ignored steps give no result. A step probes up to
// eight neighbor pairs; each pair is read in states RD0 and RD1 and compared
// in CMP, since both pixels come through the single read port of the frame
// memory. The result is registered in o_rsp in state EMIT, which waits until
// the output register is free.
// Configuration goes through i_cfg_we/i_cfg_idx/i_cfg_data: index 0 is the
// threshold, index 1 the step budget; write them only while idle.
// Reset (synchronous, active low) restores threshold 128, budget 480, ends
// any trace; frame memory contents are undefined until loaded.
// A stalled receiver holds the result; the block takes further requests but
// the next step result waits until the output register frees.
`timescale 1ns / 1ps
module dual_edge_contour_tracer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    dect_req_if.sink    i_req,
    dect_rsp_if.source  o_rsp
);

    dect_pkg::t_cmd cmd;
    dect_pkg::t_sts sts;
    logic           ready;

    assign i_req.ready = ready;

    dect_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_mode  (i_req.mode),
        .o_ready (ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    dect_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pixel_index   (i_req.pixel_index),
        .i_pixel_value   (i_req.pixel_value),
        .i_left_start_x  (i_req.left_start_x),
        .i_left_start_y  (i_req.left_start_y),
        .i_right_start_x (i_req.right_start_x),
        .i_right_start_y (i_req.right_start_y),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_rsp           (o_rsp)
    );

endmodule

[test/dect_check.sv]
`timescale 1ns / 1ps
// Checker for the dual edge contour tracer: watches config, request and result
// channels, tracks the frame and both trackers, and compares every result.
// Depends on dect_pkg, dect_req_if and dect_rsp_if.
module dect_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    dect_req_if         req,
    dect_rsp_if         rsp,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_found,
    output int          o_finished
);

    typedef struct packed {
        logic       side;
        logic       found;
        logic [7:0] point_x;
        logic [6:0] point_y;
        logic [2:0] heading;
        logic [7:0] point_number;
        logic       left_running;
        logic       right_running;
        logic       finished;
    } t_step_result;

    localparam int DX_CW[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int DY_UP[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

    logic [7:0]  frame [dect_pkg::FRAME_SIZE];
    logic [7:0]  thr;
    logic [15:0] budget;
    logic [7:0]  trk_x [2];
    logic [6:0]  trk_y [2];
    logic [2:0]  trk_dir [2];
    logic [7:0]  trk_cnt [2];
    logic        trk_on [2];
    logic [15:0] steps_rem;
    logic        done;
    t_step_result step_results [$];

    function automatic bit pixel_at(input int px, input int py, output logic [7:0] v);
        v = 8'd0;
        if (px < 0 || py < 0 || px >= dect_pkg::IMAGE_WIDTH || py >= dect_pkg::IMAGE_HEIGHT)
            return 1'b0;
        v = frame[py * dect_pkg::IMAGE_WIDTH + px];
        return 1'b1;
    endfunction

    // move tracker s along its table; the right tracker mirrors x
    function automatic bit trace_one(input int s);
        int d0, d1, sx0, sx1;
        logic [7:0] v0, v1;
        bit in0, in1;
        if (trk_cnt[s] >= dect_pkg::POINT_LIMIT - 1) begin
            trk_on[s] = 1'b0;
            return 1'b0;
        end
        for (int k = 0; k < 8; k++) begin
            d0 = (trk_dir[s] + 7 + k) & 7;
            d1 = (d0 + 1) & 7;
            sx0 = s ? -DX_CW[d0] : DX_CW[d0];
            sx1 = s ? -DX_CW[d1] : DX_CW[d1];
            in0 = pixel_at(int'(trk_x[s]) + sx0, int'(trk_y[s]) + DY_UP[d0], v0);
            in1 = pixel_at(int'(trk_x[s]) + sx1, int'(trk_y[s]) + DY_UP[d1], v1);
            if (in0 && in1 && v0 < thr && v1 > thr) begin
                trk_cnt[s] = trk_cnt[s] + 8'd1;
                trk_dir[s] = 3'(d1);
                trk_x[s] = 8'(int'(trk_x[s]) + sx1);
                trk_y[s] = 7'(int'(trk_y[s]) + DY_UP[d1]);
                return 1'b1;
            end
        end
        trk_on[s] = 1'b0;
        return 1'b0;
    endfunction

    function automatic void take_request();
        t_step_result r;
        int s, ddx, ddy;
        bit meet;
        case (req.mode)
            dect_pkg::MODE_LOAD: begin
                if (req.pixel_index < dect_pkg::FRAME_SIZE)
                    frame[req.pixel_index] = req.pixel_value;
            end
            dect_pkg::MODE_START: begin
                trk_x[0] = req.left_start_x;
                trk_y[0] = req.left_start_y;
                trk_x[1] = req.right_start_x;
                trk_y[1] = req.right_start_y;
                for (int i = 0; i < 2; i++) begin
                    trk_dir[i] = 3'd0;
                    trk_cnt[i] = 8'd0;
                    trk_on[i] = 1'b1;
                end
                steps_rem = budget;
                done = (budget == 16'd0);
            end
            dect_pkg::MODE_STEP: begin
                if (!done && (trk_on[0] || trk_on[1])) begin
                    steps_rem = steps_rem - 16'd1;
                    if (trk_on[0] && trk_on[1])
                        s = (trk_y[0] >= trk_y[1]) ? 0 : 1;
                    else
                        s = trk_on[1] ? 1 : 0;
                    r.side = 1'(s);
                    r.found = trace_one(s);
                    r.point_x = trk_x[s];
                    r.point_y = trk_y[s];
                    r.heading = trk_dir[s];
                    r.point_number = trk_cnt[s];
                    meet = 1'b0;
                    if (trk_on[0] && trk_on[1]) begin
                        ddx = int'(trk_x[0]) - int'(trk_x[1]);
                        ddy = int'(trk_y[0]) - int'(trk_y[1]);
                        if (ddx < 0) ddx = -ddx;
                        if (ddy < 0) ddy = -ddy;
                        meet = (ddx < dect_pkg::MEET_DIST && ddy < dect_pkg::MEET_DIST);
                    end
                    if (steps_rem == 16'd0 || (!trk_on[0] && !trk_on[1]) || meet)
                        done = 1'b1;
                    r.left_running = trk_on[0];
                    r.right_running = trk_on[1];
                    r.finished = done;
                    step_results.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_step_result e;
        if (!i_rst_n) begin
            thr = 8'd128;
            budget = 16'd480;
            for (int i = 0; i < 2; i++) begin
                trk_x[i] = '0;
                trk_y[i] = '0;
                trk_dir[i] = '0;
                trk_cnt[i] = '0;
                trk_on[i] = 1'b0;
            end
            steps_rem = '0;
            done = 1'b1;
            step_results.delete();
            o_errors = 0;
            o_results = 0;
            o_found = 0;
            o_finished = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == dect_pkg::CFG_THRESHOLD)
                    thr = i_cfg_data[7:0];
                else
                    budget = i_cfg_data;
            end
            if (req.valid && req.ready)
                take_request();
            if (rsp.valid && rsp.ready) begin
                if (step_results.size() == 0) begin
                    $error("result with no step request waiting");
                    o_errors++;
                end else begin
                    e = step_results.pop_front();
                    o_results++;
                    if (e.found) o_found++;
                    if (e.finished) o_finished++;
                    compare_field("side", e.side, rsp.side);
                    compare_field("found", e.found, rsp.found);
                    compare_field("point_x", e.point_x, rsp.point_x);
                    compare_field("point_y", e.point_y, rsp.point_y);
                    compare_field("heading", e.heading, rsp.heading);
                    compare_field("point_number", e.point_number, rsp.point_number);
                    compare_field("left_running", e.left_running, rsp.left_running);
                    compare_field("right_running", e.right_running, rsp.right_running);
                    compare_field("finished", e.finished, rsp.finished);
                end
            end
        end
        o_pending = step_results.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the contour tracer testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on dect_pkg, the two channel
// interfaces, dect_check and dual_edge_contour_tracer_unit.
module testbench;

    localparam int WIN_W = 16;
    localparam int WIN_H = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_data;
    int          errors, pending, results, found_pts, finishes;
    int          starts;
    bit          quiet;
    bit          long_hold;

    dect_req_if req ();
    dect_rsp_if rsp ();

    dual_edge_contour_tracer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req.sink),
        .o_rsp      (rsp.source)
    );

    dect_check checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .req        (req),
        .rsp        (rsp),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_found    (found_pts),
        .o_finished (finishes)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side back-pressure
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
                rsp.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                rsp.ready <= 1'b1;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic put(input logic [1:0] m, input logic [14:0] idx, input logic [7:0] val,
                       input logic [7:0] lx, input logic [6:0] ly,
                       input logic [7:0] rx, input logic [6:0] ry);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.mode <= m;
        req.pixel_index <= idx;
        req.pixel_value <= val;
        req.left_start_x <= lx;
        req.left_start_y <= ly;
        req.right_start_x <= rx;
        req.right_start_y <= ry;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic load_pixel(input logic [14:0] idx, input logic [7:0] val);
        put(dect_pkg::MODE_LOAD, idx, val, 8'($urandom), 7'($urandom), 8'($urandom),
            7'($urandom));
    endtask

    task automatic start_trace(input logic [7:0] lx, input logic [6:0] ly,
                               input logic [7:0] rx, input logic [6:0] ry);
        put(dect_pkg::MODE_START, 15'($urandom), 8'($urandom), lx, ly, rx, ry);
        starts++;
    endtask

    task automatic step_once();
        put(dect_pkg::MODE_STEP, 15'($urandom), 8'($urandom), 8'($urandom), 7'($urandom),
            8'($urandom), 7'($urandom));
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // start inside the loaded window, away from its dark border, or off the frame
    function automatic logic [7:0] pick_x();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(189, 255))
                                           : 8'($urandom_range(0, WIN_W - 2));
    endfunction

    function automatic logic [6:0] pick_y();
        return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(121, 127))
                                           : 7'($urandom_range(0, WIN_H - 2));
    endfunction

    task automatic random_trace(input int max_len);
        logic [7:0] lx, rx;
        logic [6:0] ly, ry;
        lx = pick_x();
        rx = pick_x();
        ly = pick_y();
        ry = pick_y();
        start_trace(lx, ly, rx, ry);
        repeat ($urandom_range(1, max_len)) begin
            case ($urandom_range(0, 29))
                0, 1, 2: load_pixel(15'($urandom_range(0, WIN_H - 2) * dect_pkg::IMAGE_WIDTH
                                        + $urandom_range(0, WIN_W - 2)), 8'($urandom));
                3: load_pixel(15'($urandom_range(dect_pkg::FRAME_SIZE, 32767)), 8'($urandom));
                4: put(dect_pkg::MODE_SPARE, 15'($urandom), 8'($urandom), 8'($urandom),
                       7'($urandom), 8'($urandom), 7'($urandom));
                default: step_once();
            endcase
        end
    endtask

    initial begin
        logic [7:0] thr_set [6] = '{8'd128, 8'd255, 8'd0, 8'd100, 8'd200, 8'd128};
        logic [15:0] budget_set [6] = '{16'd480, 16'd65535, 16'd300, 16'd3, 16'd65535, 16'd480};
        bit blk_bright [4][3];
        int goal, guard;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= 1'b0;
        cfg_data <= '0;
        req.valid <= 1'b0;
        req.mode <= dect_pkg::MODE_LOAD;
        req.pixel_index <= '0;
        req.pixel_value <= '0;
        req.left_start_x <= '0;
        req.left_start_y <= '0;
        req.right_start_x <= '0;
        req.right_start_y <= '0;
        starts = 0;
        quiet = 1'b0;
        long_hold = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle trace, unused mode, loads off the frame
        step_once();
        put(dect_pkg::MODE_SPARE, 15'h7fff, 8'hff, 8'hff, 7'h7f, 8'hff, 7'h7f);
        load_pixel(15'h7fff, 8'hff);
        load_pixel(15'(dect_pkg::FRAME_SIZE), 8'h00);

        // blocky window in the frame corner with noise, closed by a dark border
        foreach (blk_bright[bx, by]) blk_bright[bx][by] = $urandom_range(0, 2) == 0;
        for (int y = 0; y < WIN_H; y++)
            for (int x = 0; x < WIN_W; x++)
                load_pixel(15'(y * dect_pkg::IMAGE_WIDTH + x),
                           (x == WIN_W - 1 || y == WIN_H - 1) ? 8'd0 :
                           ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                           blk_bright[x / 4][y / 4] ? 8'($urandom_range(140, 255))
                                                    : 8'($urandom_range(0, 120)));

        start_trace(8'd0, 7'd0, 8'd14, 7'd10);
        repeat (6) step_once();
        start_trace(8'd255, 7'd127, 8'd200, 7'd120);
        repeat (3) step_once();
        start_trace(8'd7, 7'd5, 8'd7, 7'd5);
        repeat (3) step_once();
        write_reg(dect_pkg::CFG_MAX_STEPS, 16'd0);
        start_trace(8'd2, 7'd5, 8'd12, 7'd5);
        step_once();
        write_reg(dect_pkg::CFG_MAX_STEPS, 16'd1);
        start_trace(8'd2, 7'd5, 8'd12, 7'd5);
        repeat (2) step_once();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(dect_pkg::CFG_THRESHOLD, 16'(thr_set[ph]));
            write_reg(dect_pkg::CFG_MAX_STEPS, budget_set[ph]);
            if (ph == 5) quiet = 1'b1;
            if (ph == 0) begin
                // long trace, receiver held off so the block backs up
                long_hold = 1'b1;
                start_trace(8'($urandom_range(0, WIN_W - 2)), 7'($urandom_range(0, WIN_H - 2)),
                            8'($urandom_range(0, WIN_W - 2)), 7'($urandom_range(0, WIN_H - 2)));
                repeat (150) step_once();
                settle();
            end
            goal = results + starts + 40;
            guard = 0;
            while (results + starts < goal && guard < 200) begin
                random_trace(12);
                guard++;
            end
        end
        settle();

        $display("covered %0d starts, %0d step results, %0d with a new point, %0d ending a trace",
                 starts, results, found_pts, finishes);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
